### design/fcdam_pkg.sv
// Package: shared types and constants for the four-channel DMA audio mixer.
package fcdam_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W = 2;
  localparam logic [6:0] VOL_FULL = 7'd64;
  localparam logic [15:0] LOC_LOW_MASK = 16'hfffe;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0,
    OP_DELIVER = 3'd1,
    OP_QUERY = 3'd2,
    OP_REG_WRITE = 3'd3,
    OP_ENABLE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    SEL_LOC_HIGH = 3'd0,
    SEL_LOC_LOW = 3'd1,
    SEL_LENGTH = 3'd2,
    SEL_PERIOD = 3'd3,
    SEL_VOLUME = 3'd4
  } sel_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] channel;
    logic [2:0] reg_select;
    logic [15:0] value;
    logic [7:0] cycles;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic fetch_valid;
    logic [31:0] fetch_address;
    logic irq_raised;
  } out_item_t;

  // One channel's full state as one memory word.
  typedef struct packed {
    logic [31:0] buffer_location;
    logic [15:0] buffer_length;
    logic [15:0] period;
    logic [6:0] volume;
    logic [31:0] fetch_pointer;
    logic [15:0] words_left;
    logic [15:0] period_count;
    logic [7:0] sample_byte;
    logic [7:0] low_byte;
    logic low_byte_pending;
    logic [15:0] slot_word;
    logic slot_full;
  } chan_t;

  // Scaled sample: signed byte * 256 * volume / 64, truncated toward zero.
  function automatic logic signed [15:0] scale_sample(input logic [7:0] sb,
                                                      input logic [6:0] vol);
    logic signed [17:0] prod;
    logic signed [17:0] adj;
    begin
      prod = 18'(signed'(sb) * signed'({1'b0, vol}));
      // byte*256*vol/64 = byte*vol*4 exactly
      adj = prod <<< 2;
      scale_sample = adj[15:0];
    end
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [16:0] v);
    begin
      if (v > 17'sd32767) clamp16 = 16'sh7fff;
      else if (v < -17'sd32768) clamp16 = 16'sh8000;
      else clamp16 = v[15:0];
    end
  endfunction

endpackage

### design/fcdam_chan_ram.sv
// Channel state memory: one word per channel, registered read.
module fcdam_chan_ram
  import fcdam_pkg::*;
(
  input  logic clk,
  input  logic [CH_W-1:0] rd_addr,
  output chan_t rd_data,
  input  logic wr_en,
  input  logic [CH_W-1:0] wr_addr,
  input  chan_t wr_data
);

  chan_t mem [CHANNELS];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/fcdam_tick_unit.sv
// Tick step: runs one channel's period counter and byte sequencer.
module fcdam_tick_unit
  import fcdam_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  chan_t chan_in,
  input  logic [7:0] cycles,
  output logic done,
  output chan_t chan_out
);

  chan_t c;
  chan_t c_init;
  logic [8:0] rem;
  logic busy;

  // Turn a zero period into 1 and load a zero counter from the period
  always_comb begin
    c_init = chan_in;
    if (chan_in.period == 16'd0) begin
      c_init.period = 16'd1;
    end
    if (chan_in.period_count == 16'd0) begin
      c_init.period_count = c_init.period;
    end
  end

  // Walk expiries one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        c <= c_init;
        rem <= {1'b0, cycles};
        busy <= 1'b1;
      end else if (busy) begin
        if ({7'd0, rem} >= c.period_count) begin
          rem <= 9'(({7'd0, rem}) - c.period_count);
          c.period_count <= c.period;
          if (c.low_byte_pending) begin
            c.sample_byte <= c.low_byte;
            c.low_byte_pending <= 1'b0;
          end else if (c.slot_full) begin
            c.sample_byte <= c.slot_word[15:8];
            c.low_byte <= c.slot_word[7:0];
            c.low_byte_pending <= 1'b1;
            c.slot_full <= 1'b0;
          end
        end else begin
          c.period_count <= c.period_count - {7'd0, rem};
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign chan_out = c;

endmodule

### design/four_channel_dma_audio_mixer_top.sv
// Top level: four-channel DMA audio mixer with stereo mix.
// Channel state lives in a four-word synchronous memory, cleared by a pass
// after reset during which the input is stalled. One item is taken at a
// time. A delivery, query, register write, enable write or ignored item reads
// its channel; a delivery or register write modifies it and writes it back. The
// input is busy through the READ and MOD states, and the result is registered in
// MOD. A tick reads each channel in turn and runs the period counter of each
// enabled channel one expiry per cycle. The mix is kept in registers (samples
// and volumes mirrored per channel) and updated after a tick. The result sits
// in an output register; the next item is accepted in the cycle it is taken.
module four_channel_dma_audio_mixer_top
  import fcdam_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_data
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_READ = 8'b00000010,
    ST_MOD = 8'b00000100,
    ST_TREAD = 8'b00001000,
    ST_TSTART = 8'b00010000,
    ST_TRUN = 8'b00100000,
    ST_MIX = 8'b01000000,
    ST_CLEAR = 8'b10000000
  } state_t;

  state_t state;
  in_item_t item;
  logic [3:0] dma_enables;
  logic [CH_W:0] tch;
  logic [7:0] samp [CHANNELS];
  logic [6:0] vol [CHANNELS];
  logic signed [15:0] mix_l, mix_r;

  logic [CH_W-1:0] rd_addr;
  chan_t rd_data;
  logic wr_en;
  logic [CH_W-1:0] wr_addr;
  chan_t wr_data;
  logic t_start, t_done;
  chan_t t_out;
  chan_t m;
  logic res_fetch_valid;
  logic [31:0] res_fetch_address;
  logic res_irq;

  fcdam_chan_ram u_ram (
    .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  fcdam_tick_unit u_tick (
    .clk(clk), .rst(rst), .start(t_start), .chan_in(rd_data),
    .cycles(item.cycles), .done(t_done), .chan_out(t_out)
  );

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign rd_addr = (state == ST_TREAD) ? tch[CH_W-1:0] : item.channel;
  assign t_start = (state == ST_TSTART);

  // Modify one channel word for a non-tick item
  always_comb begin
    m = rd_data;
    case (item.operation)
      OP_DELIVER: begin
        m.slot_word = item.value;
        m.slot_full = 1'b1;
        m.fetch_pointer = rd_data.fetch_pointer + 32'd2;
        if (rd_data.words_left != 16'd0) m.words_left = rd_data.words_left - 16'd1;
        if (m.words_left == 16'd0) begin
          m.fetch_pointer = rd_data.buffer_location;
          m.words_left = rd_data.buffer_length;
        end
      end
      OP_REG_WRITE: begin
        case (item.reg_select)
          SEL_LOC_HIGH: m.buffer_location[31:16] = item.value;
          SEL_LOC_LOW: m.buffer_location[15:0] = item.value & LOC_LOW_MASK;
          SEL_LENGTH: begin
            m.buffer_length = item.value;
            if (rd_data.words_left == 16'd0) begin
              m.words_left = item.value;
              m.fetch_pointer = rd_data.buffer_location;
            end
          end
          SEL_PERIOD: m.period = (item.value == 16'd0) ? 16'd1 : item.value;
          SEL_VOLUME: m.volume = (item.value[6:0] > VOL_FULL) ? VOL_FULL : item.value[6:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Query and interrupt fields of a non-tick result
  always_comb begin
    res_fetch_valid = 1'b0;
    res_fetch_address = 32'd0;
    res_irq = 1'b0;
    case (item.operation)
      OP_DELIVER: res_irq = (rd_data.words_left <= 16'd1);
      OP_QUERY: begin
        res_fetch_valid = dma_enables[item.channel] &&
                          rd_data.words_left != 16'd0 && !rd_data.slot_full;
        res_fetch_address = rd_data.fetch_pointer;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = item.channel;
    wr_data = m;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = tch[CH_W-1:0];
      wr_data = '0;
    end else if (state == ST_MOD &&
        (item.operation == OP_DELIVER || item.operation == OP_REG_WRITE)) begin
      wr_en = 1'b1;
    end else if (state == ST_TRUN && t_done) begin
      wr_en = 1'b1;
      wr_addr = tch[CH_W-1:0];
      wr_data = t_out;
    end
  end

  // Sequence items and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      tch <= '0;
      out_valid <= 1'b0;
      dma_enables <= 4'd0;
      mix_l <= 16'sd0;
      mix_r <= 16'sd0;
      for (int i = 0; i < CHANNELS; i++) begin
        samp[i] <= 8'd0;
        vol[i] <= 7'd0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          tch <= tch + 1'b1;
          if (&tch[CH_W-1:0]) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            item <= in_data;
            if (in_data.operation == OP_TICK) begin
              tch <= '0;
              state <= ST_TREAD;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: state <= ST_MOD;
        ST_MOD: begin
          out_data.mix_left <= mix_l;
          out_data.mix_right <= mix_r;
          out_data.fetch_valid <= res_fetch_valid;
          out_data.fetch_address <= res_fetch_address;
          out_data.irq_raised <= res_irq;
          if (item.operation == OP_ENABLE) dma_enables <= item.value[3:0];
          if (item.operation == OP_REG_WRITE && item.reg_select == SEL_VOLUME) begin
            vol[item.channel] <= m.volume;
          end
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        ST_TREAD: begin
          if (tch[CH_W]) state <= ST_MIX;
          else if (!dma_enables[tch[CH_W-1:0]]) tch <= tch + 1'b1;
          else state <= ST_TSTART;
        end
        ST_TSTART: state <= ST_TRUN;
        ST_TRUN: begin
          if (t_done) begin
            samp[tch[CH_W-1:0]] <= t_out.sample_byte;
            tch <= tch + 1'b1;
            state <= ST_TREAD;
          end
        end
        ST_MIX: begin
          mix_l <= clamp16(17'(scale_sample(samp[0], vol[0])) +
                           17'(scale_sample(samp[3], vol[3])));
          mix_r <= clamp16(17'(scale_sample(samp[1], vol[1])) +
                           17'(scale_sample(samp[2], vol[2])));
          out_data.mix_left <= clamp16(17'(scale_sample(samp[0], vol[0])) +
                                       17'(scale_sample(samp[3], vol[3])));
          out_data.mix_right <= clamp16(17'(scale_sample(samp[1], vol[1])) +
                                        17'(scale_sample(samp[2], vol[2])));
          out_data.fetch_valid <= 1'b0;
          out_data.fetch_address <= 32'd0;
          out_data.irq_raised <= 1'b0;
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/fcdam_checker.sv
// Port checker for the four-channel DMA audio mixer, bound to the top level.
module fcdam_checker
  import fcdam_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_item_t in_data,
  input logic out_valid,
  input logic out_stall,
  input out_item_t out_data
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // No transfer in while a result waits stalled
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");

  // An interrupt result without a fetch has its fetch address cleared
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.fetch_valid && out_data.irq_raised |-> out_data.fetch_address == 32'd0)
    else $error("fetch address on non-query");

  // A result that reports a fetch never raises the interrupt
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fetch_valid |-> !out_data.irq_raised)
    else $error("query and interrupt together");

endmodule

bind four_channel_dma_audio_mixer_top fcdam_checker u_fcdam_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

### tb/sv/tb_four_channel_dma_audio_mixer_top.sv
// Testbench for the four-channel DMA audio mixer: directed and random items vs. a predictor.
`timescale 1ns / 100ps

module tb_four_channel_dma_audio_mixer_top
  import fcdam_pkg::*;
;

class mixer_scoreboard;
  logic [31:0] buf_loc[4];
  logic [15:0] buf_len[4];
  logic [15:0] per[4];
  logic [6:0]  vol[4];
  logic [31:0] fptr[4];
  logic [15:0] left_words[4];
  logic [15:0] pcount[4];
  logic [7:0]  smp[4];
  logic [7:0]  lo_byte[4];
  bit          lo_pend[4];
  logic [15:0] slot[4];
  bit          slot_busy[4];
  logic [3:0]  enables;
  logic signed [15:0] mix_l, mix_r;
  out_item_t   pending_results[$];
  int          errors;
  int          matched;

  function new();
    for (int c = 0; c < 4; c++) begin
      buf_loc[c] = 0; buf_len[c] = 0; per[c] = 0; vol[c] = 0; fptr[c] = 0;
      left_words[c] = 0; pcount[c] = 0; smp[c] = 0; lo_byte[c] = 0;
      lo_pend[c] = 0; slot[c] = 0; slot_busy[c] = 0;
    end
    enables = 0; mix_l = 0; mix_r = 0; errors = 0; matched = 0;
  endfunction

  function int scaled(int c);
    int s;
    s = $signed(smp[c]);
    return (s * 256 * int'(vol[c])) / 64;
  endfunction

  function logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Advance the byte sequencer of one channel.
  function void play_byte(int c);
    if (lo_pend[c]) begin
      smp[c] = lo_byte[c];
      lo_pend[c] = 0;
    end else if (slot_busy[c]) begin
      smp[c] = slot[c][15:8];
      lo_byte[c] = slot[c][7:0];
      lo_pend[c] = 1;
      slot_busy[c] = 0;
    end
  endfunction

  function void run_tick(int cyc);
    int rem;
    for (int c = 0; c < 4; c++) begin
      if (!enables[c]) continue;
      rem = cyc;
      if (per[c] == 0) per[c] = 1;
      if (pcount[c] == 0) pcount[c] = per[c];
      while (rem >= pcount[c]) begin
        rem -= pcount[c];
        pcount[c] = per[c];
        play_byte(c);
      end
      pcount[c] = pcount[c] - 16'(rem);
    end
    mix_l = sat16(scaled(0) + scaled(3));
    mix_r = sat16(scaled(1) + scaled(2));
  endfunction

  // Note an accepted input and queue its expected result.
  function void note_input(in_item_t it);
    out_item_t r;
    int c;
    c = it.channel;
    r = '0;
    case (it.operation)
      OP_TICK: run_tick(it.cycles);
      OP_DELIVER: begin
        slot[c] = it.value;
        slot_busy[c] = 1;
        fptr[c] = fptr[c] + 2;
        if (left_words[c] > 0) left_words[c]--;
        if (left_words[c] == 0) begin
          fptr[c] = buf_loc[c];
          left_words[c] = buf_len[c];
          r.irq_raised = 1;
        end
      end
      OP_QUERY: begin
        r.fetch_valid = enables[c] && left_words[c] != 0 && !slot_busy[c];
        r.fetch_address = fptr[c];
      end
      OP_REG_WRITE: begin
        case (it.reg_select)
          SEL_LOC_HIGH: buf_loc[c][31:16] = it.value;
          SEL_LOC_LOW: buf_loc[c][15:0] = it.value & LOC_LOW_MASK;
          SEL_LENGTH: begin
            buf_len[c] = it.value;
            if (left_words[c] == 0) begin
              left_words[c] = it.value;
              fptr[c] = buf_loc[c];
            end
          end
          SEL_PERIOD: per[c] = (it.value == 0) ? 16'd1 : it.value;
          SEL_VOLUME: vol[c] = (it.value[6:0] > VOL_FULL) ? VOL_FULL : it.value[6:0];
          default: ;
        endcase
      end
      OP_ENABLE: enables = it.value[3:0];
      default: ;
    endcase
    r.mix_left = mix_l;
    r.mix_right = mix_r;
    pending_results.push_back(r);
  endfunction

  // Compare one result with the oldest expectation.
  function void check_result(out_item_t got);
    out_item_t exp;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.mix_left !== exp.mix_left) begin
      $display("%0t: mix_left exp %0d got %0d", $time, exp.mix_left, got.mix_left);
      errors++;
    end
    if (got.mix_right !== exp.mix_right) begin
      $display("%0t: mix_right exp %0d got %0d", $time, exp.mix_right, got.mix_right);
      errors++;
    end
    if (got.fetch_valid !== exp.fetch_valid) begin
      $display("%0t: fetch_valid exp %0b got %0b", $time, exp.fetch_valid,
               got.fetch_valid);
      errors++;
    end
    if (got.fetch_address !== exp.fetch_address) begin
      $display("%0t: fetch_address exp %h got %h", $time, exp.fetch_address,
               got.fetch_address);
      errors++;
    end
    if (got.irq_raised !== exp.irq_raised) begin
      $display("%0t: irq_raised exp %0b got %0b", $time, exp.irq_raised, got.irq_raised);
      errors++;
    end
    matched++;
  endfunction
endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1;
  out_item_t out_data;
  bit calm_phase = 0;
  int ticks_sent = 0;
  int irqs_seen = 0;
  mixer_scoreboard board;

  four_channel_dma_audio_mixer_top DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function bit idle_now();
    return !calm_phase && ($urandom_range(99) < 34);
  endfunction

  // Hold one item until the transfer completes, with optional idle gap first.
  task automatic send_item(in_item_t it);
    while (idle_now()) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    board.note_input(it);
    if (it.operation == OP_TICK) ticks_sent++;
  endtask

  task automatic send_fields(int op, int ch, int sel, int val, int cyc);
    in_item_t it;
    it.operation = 3'(op); it.channel = 2'(ch); it.reg_select = 3'(sel);
    it.value = 16'(val); it.cycles = 8'(cyc);
    send_item(it);
  endtask

  // Receiver side: random stall, check each transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        board.check_result(out_data);
        if (out_data.irq_raised) irqs_seen++;
      end
      out_stall <= idle_now();
    end
  end

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    it.channel = 2'($urandom_range(3));
    it.value = 16'($urandom);
    it.cycles = 8'($urandom_range(255));
    it.reg_select = 3'($urandom_range(4));
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.operation = OP_TICK;
      if ($urandom_range(3) != 0) it.cycles = 8'($urandom_range(40));
    end else if (pick < 50) it.operation = OP_DELIVER;
    else if (pick < 65) it.operation = OP_QUERY;
    else if (pick < 88) begin
      it.operation = OP_REG_WRITE;
      // keep buffers short and periods small most of the time
      if (it.reg_select == SEL_LENGTH && $urandom_range(3) != 0)
        it.value = 16'($urandom_range(6));
      if (it.reg_select == SEL_PERIOD && $urandom_range(3) != 0)
        it.value = 16'($urandom_range(12));
      if ($urandom_range(19) == 0) it.reg_select = 3'($urandom_range(7, 5));
    end else if (pick < 97) begin
      it.operation = OP_ENABLE;
      if ($urandom_range(1)) it.value[3:0] = 4'hf;
    end else it.operation = 3'($urandom_range(7, 5));
    return it;
  endfunction

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: registers, extremes, special cases.
    send_fields(OP_QUERY, 0, 0, 0, 0);
    send_fields(OP_DELIVER, 1, 0, 16'h1234, 0);
    send_fields(OP_REG_WRITE, 0, SEL_LOC_HIGH, 16'hffff, 0);
    send_fields(OP_REG_WRITE, 0, SEL_LOC_LOW, 16'hffff, 0);
    send_fields(OP_REG_WRITE, 0, SEL_LENGTH, 16'd2, 0);
    send_fields(OP_REG_WRITE, 0, SEL_PERIOD, 16'd0, 0);
    send_fields(OP_REG_WRITE, 0, SEL_VOLUME, 16'hffff, 0);
    send_fields(OP_REG_WRITE, 3, SEL_VOLUME, 16'd64, 0);
    send_fields(OP_REG_WRITE, 3, SEL_PERIOD, 16'hffff, 0);
    send_fields(OP_REG_WRITE, 1, SEL_VOLUME, 16'h0040, 0);
    send_fields(OP_REG_WRITE, 2, SEL_VOLUME, 16'h0041, 0);
    send_fields(OP_REG_WRITE, 1, 3'd7, 16'hffff, 0);
    send_fields(OP_ENABLE, 0, 0, 16'hffff, 0);
    send_fields(OP_QUERY, 0, 0, 0, 0);
    send_fields(OP_DELIVER, 0, 0, 16'h8080, 0);
    send_fields(OP_DELIVER, 0, 0, 16'h807f, 0);
    send_fields(OP_DELIVER, 1, 0, 16'h8000, 0);
    send_fields(OP_DELIVER, 2, 0, 16'h80ff, 0);
    send_fields(OP_TICK, 0, 0, 0, 8'd255);
    send_fields(OP_TICK, 0, 0, 0, 8'd0);
    send_fields(OP_TICK, 0, 0, 0, 8'd1);
    send_fields(OP_QUERY, 3, 0, 0, 0);
    send_fields(3'd7, 3, 7, 16'hffff, 8'hff);
    send_fields(OP_ENABLE, 0, 0, 16'h0000, 0);
    send_fields(OP_TICK, 0, 0, 0, 8'd200);
    // Random part with a calm stretch in the middle.
    for (int i = 0; i < 750; i++) begin
      calm_phase = (i >= 300 && i < 400);
      send_item(random_item());
    end
    in_valid <= 0;
    calm_phase = 1;
    fork
      begin
        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
      end
    join
    $display("Covered %0d results, %0d ticks, %0d buffer wraps.",
             board.matched, ticks_sent, irqs_seen);
    if (board.errors == 0 && board.pending_results.size() == 0)
      $display("tb_four_channel_dma_audio_mixer_top passed");
    else
      $display("tb_four_channel_dma_audio_mixer_top failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_four_channel_dma_audio_mixer_top failed");
    $finish;
  end
endmodule

### four_channel_dma_audio_mixer_top.f
design/fcdam_pkg.sv
design/fcdam_chan_ram.sv
design/fcdam_tick_unit.sv
design/four_channel_dma_audio_mixer_top.sv
design/fcdam_checker.sv
tb/sv/tb_four_channel_dma_audio_mixer_top.sv
